[rtl/assert_macros.svh]
// Assertion macros, included by glr_dp.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/glr_pkg.sv]
`timescale 1ns / 1ps
package glr_pkg;

  localparam int CoordW       = 6;
  localparam int ColorW       = 24;
  localparam int ChanW        = 8;
  localparam int KW           = 7;
  localparam int DefCoordRange = 64;
  localparam int Percent      = 100;
  // floor(v/100) == (v*5243)>>19 for v below 43690
  localparam int RecipMul     = 5243;
  localparam int RecipShift   = 19;
  localparam int NumW         = 16;
  localparam int ScaledW      = 29;

  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    logic [ColorW-1:0] start_rgb;
    logic [ColorW-1:0] end_rgb;
  } glr_in_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [ColorW-1:0] pixel_rgb;
    logic              last_pixel;
  } glr_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_EMIT
  } glr_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul1;
    logic mul2;
    logic advance;
  } glr_cmd_t;

  typedef struct packed {
    logic span_zero;
    logic div_done;
    logic last;
  } glr_status_t;

endpackage

[rtl/glr_ctrl.sv]
`timescale 1ns / 1ps
module glr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  glr_pkg::glr_status_t sts,
  output glr_pkg::glr_cmd_t    cmd
);

  glr_pkg::glr_state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= glr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      glr_pkg::ST_IDLE: if (in_valid) state_nxt = glr_pkg::ST_DIV;
      glr_pkg::ST_DIV:  if (sts.span_zero || sts.div_done) state_nxt = glr_pkg::ST_MUL1;
      glr_pkg::ST_MUL1: state_nxt = glr_pkg::ST_MUL2;
      glr_pkg::ST_MUL2: state_nxt = glr_pkg::ST_EMIT;
      glr_pkg::ST_EMIT: begin
        if (!out_stall) state_nxt = sts.last ? glr_pkg::ST_IDLE : glr_pkg::ST_MUL1;
      end
      default: state_nxt = glr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      glr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      glr_pkg::ST_DIV:  cmd.div_step = !(sts.span_zero || sts.div_done);
      glr_pkg::ST_MUL1: cmd.mul1 = 1'b1;
      glr_pkg::ST_MUL2: cmd.mul2 = 1'b1;
      glr_pkg::ST_EMIT: begin
        out_valid   = 1'b1;
        cmd.advance = !out_stall && !sts.last;
      end
      default: ;
    endcase
  end

endmodule

[rtl/glr_dp.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module glr_dp #(
  parameter int COORD_RANGE = glr_pkg::DefCoordRange
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  glr_pkg::glr_in_t     in_data,
  output glr_pkg::glr_out_t    out_data,
  input  glr_pkg::glr_cmd_t    cmd,
  output glr_pkg::glr_status_t sts
);

  localparam int CW = glr_pkg::CoordW;
  localparam logic [CW:0] MaxC = (COORD_RANGE > (1 << CW)) ? (CW+1)'((1 << CW) - 1)
                                                          : (CW+1)'(COORD_RANGE - 1);

  logic [CW-1:0] sma_r, smi_r, span_r, mspan_r, d_r, off_r, offrem_r, krem_r, drem_r;
  logic          xmajor_r, dec_r, ceil_r;
  logic [glr_pkg::ColorW-1:0] sc_r, ec_r;
  logic [glr_pkg::KW-1:0]     k_r, dvd_r;
  logic [2:0]                 dcnt_r;
  logic [14:0]                prod_r [3];
  logic [glr_pkg::ScaledW-1:0] scaled_r [3];

  logic [CW-1:0] ax, ay, bx, by, dx, dy;
  logic          xmaj;
  logic [CW-1:0] l_sma, l_smi, l_emi;
  logic [glr_pkg::ColorW-1:0] l_sc, l_ec;
  logic [CW:0]   rem_sh, osum, ksum;
  logic [CW-1:0] off_eff, minor, major;
  logic [glr_pkg::ChanW-1:0] cha [3];
  logic [glr_pkg::ChanW-1:0] chb [3];
  logic [glr_pkg::NumW-1:0]  num [3];

  function automatic logic [CW-1:0] clampc(input logic [CW-1:0] v);
    return ({1'b0, v} > MaxC) ? MaxC[CW-1:0] : v;
  endfunction

  // order endpoints along the major axis
  always_comb begin
    ax = clampc(in_data.start_x);
    ay = clampc(in_data.start_y);
    bx = clampc(in_data.end_x);
    by = clampc(in_data.end_y);
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    xmaj = dx >= dy;
    if (xmaj ? (ax > bx) : (ay > by)) begin
      l_sma = xmaj ? bx : by;  l_smi = xmaj ? by : bx;
      l_emi = xmaj ? ay : ax;
      l_sc  = in_data.end_rgb; l_ec  = in_data.start_rgb;
    end else begin
      l_sma = xmaj ? ax : ay;  l_smi = xmaj ? ay : ax;
      l_emi = xmaj ? by : bx;
      l_sc  = in_data.start_rgb; l_ec = in_data.end_rgb;
    end
  end

  // step sums
  assign rem_sh = {drem_r, dvd_r[glr_pkg::KW-1]};
  assign osum   = {1'b0, offrem_r} + {1'b0, mspan_r};
  assign ksum   = {1'b0, krem_r} + {1'b0, drem_r};

  // color channel arithmetic
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cha[c] = sc_r[c*glr_pkg::ChanW +: glr_pkg::ChanW];
      chb[c] = ec_r[c*glr_pkg::ChanW +: glr_pkg::ChanW];
      num[c] = (cha[c] >= chb[c])
        ? glr_pkg::NumW'(cha[c]) * glr_pkg::NumW'(glr_pkg::Percent) - glr_pkg::NumW'(prod_r[c])
        : glr_pkg::NumW'(cha[c]) * glr_pkg::NumW'(glr_pkg::Percent) + glr_pkg::NumW'(prod_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r   <= '0;
      mspan_r  <= '0;
      offrem_r <= '0;
      krem_r   <= '0;
      drem_r   <= '0;
      k_r      <= '0;
      dcnt_r   <= '0;
    end else if (cmd.load) begin
      // capture the ordered segment, arm the 100/span divider
      sma_r    <= l_sma;
      smi_r    <= l_smi;
      sc_r     <= l_sc;
      ec_r     <= l_ec;
      xmajor_r <= xmaj;
      span_r   <= xmaj ? dx : dy;
      mspan_r  <= xmaj ? dy : dx;
      dec_r    <= l_emi < l_smi;
      ceil_r   <= !xmaj && (l_emi < l_smi);
      d_r      <= '0;
      off_r    <= '0;
      offrem_r <= '0;
      k_r      <= '0;
      krem_r   <= '0;
      dvd_r    <= glr_pkg::KW'(glr_pkg::Percent);
      drem_r   <= '0;
      dcnt_r   <= 3'(glr_pkg::KW);
    end else begin
      // restoring divide, one quotient bit a cycle
      if (cmd.div_step) begin
        dcnt_r <= dcnt_r - 3'd1;
        if (rem_sh >= {1'b0, span_r}) begin
          drem_r <= CW'(rem_sh - {1'b0, span_r});
          dvd_r  <= {dvd_r[glr_pkg::KW-2:0], 1'b1};
        end else begin
          drem_r <= rem_sh[CW-1:0];
          dvd_r  <= {dvd_r[glr_pkg::KW-2:0], 1'b0};
        end
      end
      // form channel products
      if (cmd.mul1) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[c] <= 15'(((cha[c] >= chb[c]) ? cha[c] - chb[c] : chb[c] - cha[c])) *
                       15'(k_r);
        end
      end
      // scale by 1/100
      if (cmd.mul2) begin
        for (int c = 0; c < 3; c++) begin
          scaled_r[c] <= glr_pkg::ScaledW'(num[c]) * glr_pkg::ScaledW'(glr_pkg::RecipMul);
        end
      end
      // advance to the next major position
      if (cmd.advance) begin
        d_r <= d_r + 1'b1;
        if (osum >= {1'b0, span_r}) begin
          off_r    <= off_r + 1'b1;
          offrem_r <= CW'(osum - {1'b0, span_r});
        end else begin
          offrem_r <= osum[CW-1:0];
        end
        if (ksum >= {1'b0, span_r}) begin
          k_r    <= k_r + dvd_r + 1'b1;
          krem_r <= CW'(ksum - {1'b0, span_r});
        end else begin
          k_r    <= k_r + dvd_r;
          krem_r <= ksum[CW-1:0];
        end
      end
    end
  end

  // pixel assembly
  always_comb begin
    off_eff = off_r + CW'(ceil_r && (offrem_r != '0));
    minor   = dec_r ? smi_r - off_eff : smi_r + off_eff;
    major   = sma_r + d_r;
    out_data.pixel_x    = xmajor_r ? major : minor;
    out_data.pixel_y    = xmajor_r ? minor : major;
    out_data.last_pixel = d_r == span_r;
    for (int c = 0; c < 3; c++) begin
      out_data.pixel_rgb[c*glr_pkg::ChanW +: glr_pkg::ChanW] =
        scaled_r[c][glr_pkg::RecipShift +: glr_pkg::ChanW];
    end
  end

  assign sts.span_zero = span_r == '0;
  assign sts.div_done  = dcnt_r == '0;
  assign sts.last      = d_r == span_r;

  `ASSERT_IMPL(a_offrem_lt_span, clk, rst_n, span_r != '0, offrem_r < span_r)
  `ASSERT_IMPL(a_k_bounded, clk, rst_n, 1'b1, k_r <= glr_pkg::KW'(glr_pkg::Percent))
  `ASSERT_NEXT(a_adv_steps_d, clk, rst_n, cmd.advance && !cmd.load, d_r == $past(d_r) + 1'b1)

endmodule

[rtl/gradient_line_rasterizer.sv]
`timescale 1ns / 1ps
// Line segment rasterizer with per-pixel RGB interpolation.
// Input channel (in_valid/in_stall/in_data): one segment per transfer, two
// tile-local endpoints and their colors. The endpoints are ordered along the
// major axis (x on equal spans) and one pixel is produced per major step.
// Output channel (out_valid/out_stall/out_data): one pixel per transfer, with
// last_pixel set on the final pixel of the segment.
// Sequence: after the segment transfer, a bit-serial divider computes 100/span
// (no divide steps for a single point), then each pixel passes through the
// two multiply steps (products, then scaling by 1/100) before it is
// offered.
// One segment is processed at a time: in_stall is high from the segment
// transfer until the last pixel has transferred.
// While out_stall is high the current pixel is held unchanged.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// any segment in progress.
module gradient_line_rasterizer #(
  parameter int COORD_RANGE = glr_pkg::DefCoordRange
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  glr_pkg::glr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output glr_pkg::glr_out_t out_data
);

  glr_pkg::glr_cmd_t    cmd;
  glr_pkg::glr_status_t sts;

  glr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  glr_dp #(
    .COORD_RANGE (COORD_RANGE)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

[tb/gradient_line_rasterizer_checker.sv]
`timescale 1ns / 1ps
module gradient_line_rasterizer_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  glr_pkg::glr_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  glr_pkg::glr_out_t out_data,
  output int                fail_count,
  output int                pending_pixels
);

  glr_pkg::glr_out_t pixel_queue[$];

  assign pending_pixels = pixel_queue.size();

  // Blend one 8-bit channel at percent k, truncating.
  function automatic logic [7:0] blend_channel(input int unsigned ca, input int unsigned cb,
                                               input int unsigned k);
    if (ca >= cb) return 8'((ca * 100 - (ca - cb) * k) / 100);
    return 8'((ca * 100 + (cb - ca) * k) / 100);
  endfunction

  // Expand one segment into its pixels.
  task automatic rasterize_segment(input glr_pkg::glr_in_t seg);
    int unsigned ax, ay, bx, by, dx, dy, sma, smi, emi, span, mspan, off, k, minor;
    logic [23:0] sc, ec, rgb;
    logic xmajor;
    glr_pkg::glr_out_t px;
    ax = seg.start_x; ay = seg.start_y; bx = seg.end_x; by = seg.end_y;
    dx = ax > bx ? ax - bx : bx - ax;
    dy = ay > by ? ay - by : by - ay;
    xmajor = dx >= dy;
    if (xmajor) begin
      if (ax > bx) begin
        sma = bx; smi = by; emi = ay; sc = seg.end_rgb; ec = seg.start_rgb;
      end else begin
        sma = ax; smi = ay; emi = by; sc = seg.start_rgb; ec = seg.end_rgb;
      end
      span = dx; mspan = dy;
    end else begin
      if (ay > by) begin
        sma = by; smi = bx; emi = ax; sc = seg.end_rgb; ec = seg.start_rgb;
      end else begin
        sma = ay; smi = ax; emi = bx; sc = seg.start_rgb; ec = seg.end_rgb;
      end
      span = dy; mspan = dx;
    end
    for (int unsigned d = 0; d <= span; d++) begin
      if (span == 0) off = 0;
      else if (!xmajor && emi < smi) off = (d * mspan + span - 1) / span;
      else off = d * mspan / span;
      minor = emi >= smi ? smi + off : smi - off;
      if (span == 0) begin
        rgb = sc;
      end else begin
        k = d * 100 / span;
        rgb = {blend_channel(sc[23:16], ec[23:16], k), blend_channel(sc[15:8], ec[15:8], k),
               blend_channel(sc[7:0], ec[7:0], k)};
      end
      px.pixel_x = xmajor ? 6'(sma + d) : 6'(minor);
      px.pixel_y = xmajor ? 6'(minor) : 6'(sma + d);
      px.pixel_rgb = rgb;
      px.last_pixel = d == span;
      pixel_queue.push_back(px);
    end
  endtask

  // Predict on segment transfers, compare on pixel transfers.
  always @(posedge clk) begin
    glr_pkg::glr_out_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixel_queue.size() == 0) begin
          $error("unexpected pixel %p", out_data);
          errs++;
        end else begin
          want = pixel_queue.pop_front();
          if (out_data.pixel_x !== want.pixel_x) begin
            $error("pixel_x expected %0d actual %0d", want.pixel_x, out_data.pixel_x);
            errs++;
          end
          if (out_data.pixel_y !== want.pixel_y) begin
            $error("pixel_y expected %0d actual %0d", want.pixel_y, out_data.pixel_y);
            errs++;
          end
          if (out_data.pixel_rgb !== want.pixel_rgb) begin
            $error("pixel_rgb expected %h actual %h", want.pixel_rgb, out_data.pixel_rgb);
            errs++;
          end
          if (out_data.last_pixel !== want.last_pixel) begin
            $error("last_pixel expected %b actual %b", want.last_pixel, out_data.last_pixel);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (in_valid && !in_stall) rasterize_segment(in_data);
    end
  end
endmodule

[tb/gradient_line_rasterizer_test.sv]
`timescale 1ns / 1ps
module gradient_line_rasterizer_test;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  glr_pkg::glr_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  glr_pkg::glr_out_t out_data;
  int                fail_count;
  int                pending_pixels;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;

  always #6 clk = ~clk;

  gradient_line_rasterizer DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  gradient_line_rasterizer_checker checker_inst (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_pixels(pending_pixels)
  );

  // Randomly stall the pixel channel.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Drop valid for one cycle.
  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Present one segment, with a random idle gap, and hold until transfer.
  task automatic send_segment(input glr_pkg::glr_in_t seg);
    if ($urandom_range(99) < send_idle_pct) begin
      idle_input();
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= seg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                           input logic [23:0] sc, input logic [23:0] ec);
    glr_pkg::glr_in_t seg;
    seg.start_x = 6'(sx); seg.start_y = 6'(sy); seg.end_x = 6'(ex); seg.end_y = 6'(ey);
    seg.start_rgb = sc; seg.end_rgb = ec;
    send_segment(seg);
  endtask

  // Mostly short lines, some random-length, a few full-tile.
  task automatic send_random_segment();
    glr_pkg::glr_in_t seg;
    int sel;
    seg.start_x = 6'($urandom);
    seg.start_y = 6'($urandom);
    seg.end_x = 6'($urandom);
    seg.end_y = 6'($urandom);
    seg.start_rgb = 24'($urandom);
    seg.end_rgb = 24'($urandom);
    sel = $urandom_range(9);
    if (sel < 6) begin
      seg.end_x = 6'(int'(seg.start_x) + $urandom_range(8) - 4);
      seg.end_y = 6'(int'(seg.start_y) + $urandom_range(8) - 4);
    end else if (sel == 9) begin
      seg.start_x = $urandom_range(1) ? 6'd63 : 6'd0;
      seg.end_x = ~seg.start_x;
    end
    send_segment(seg);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: points, axes, diagonals, both directions, color extremes.
    send_line(0, 0, 0, 0, 24'h123456, 24'hFFFFFF);
    send_line(63, 63, 63, 63, 24'hFFFFFF, 24'h000000);
    send_line(0, 0, 63, 0, 24'h000000, 24'hFFFFFF);
    send_line(63, 0, 0, 0, 24'h000000, 24'hFFFFFF);
    send_line(0, 0, 0, 63, 24'hFFFFFF, 24'h000000);
    send_line(0, 63, 0, 0, 24'hFF00FF, 24'h00FF00);
    send_line(0, 0, 63, 63, 24'hAA55AA, 24'h55AA55);
    send_line(63, 0, 0, 63, 24'h0F0F0F, 24'hF0F0F0);
    send_line(10, 5, 20, 8, 24'h102030, 24'h302010);
    send_line(20, 8, 10, 5, 24'h102030, 24'h302010);
    send_line(5, 10, 8, 30, 24'hFFFF00, 24'h00FFFF);
    send_line(8, 10, 5, 30, 24'hFFFF00, 24'h00FFFF);
    send_line(8, 30, 5, 10, 24'h808080, 24'h7F7F7F);
    send_line(3, 40, 60, 2, 24'h010203, 24'hFEFDFC);
    send_line(30, 30, 31, 31, 24'h000000, 24'hFFFFFF);
    send_line(30, 30, 31, 33, 24'h000000, 24'hFFFFFF);
    send_line(31, 30, 30, 33, 24'hFFFFFF, 24'h000000);

    // Random phases with swapped idle ratios, then no idling.
    send_idle_pct = 16; recv_stall_pct = 83;
    repeat (55) send_random_segment();
    // Pause until all pixels have drained.
    idle_input();
    while (pending_pixels != 0) @(posedge clk);
    send_idle_pct = 83; recv_stall_pct = 16;
    repeat (55) send_random_segment();
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (60) send_random_segment();

    idle_input();
    while (pending_pixels != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("gradient_line_rasterizer: match");
    else $display("gradient_line_rasterizer: mismatch");
    $finish;
  end

  // Hard limit on run time.
  initial begin
    #20ms;
    $display("gradient_line_rasterizer: mismatch");
    $finish;
  end
endmodule
